### rtl/sgb_pkg.sv
package sgb_pkg;

    localparam int DATA_W      = 16;
    localparam int FRAC_W      = 12;
    localparam int COL_W       = 8;
    localparam int BIAS_W      = 32;
    localparam int COLUMNS_DEF = 256;

    // Shared multiplier operand and product widths.
    localparam int OPND_W = DATA_W + 4;
    localparam int PROD_W = 2 * OPND_W;

    // Sigmoid values lie in [0, 1.0] and need one bit above the fraction.
    localparam int SIG_W  = FRAC_W + 1;
    localparam int ONE_Q  = 1 << FRAC_W;

    // Breakpoints of the piecewise linear sigmoid.
    localparam int SIG_SAT_TH = 5 * ONE_Q;
    localparam int SIG_MID_TH = (19 * ONE_Q) / 8;

    typedef struct packed {
        logic signed [DATA_W-1:0] grad_out;
        logic signed [DATA_W-1:0] grad_recurrent;
        logic signed [DATA_W-1:0] h_new_value;
        logic signed [DATA_W-1:0] gate_pre;
        logic signed [DATA_W-1:0] gate_value;
        logic        [COL_W-1:0]  column;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] grad_h_new;
        logic signed [DATA_W-1:0] grad_gate_pre;
        logic signed [BIAS_W-1:0] bias_total;
        logic                     saturated;
    } t_out_beat;

    // Piecewise linear sigmoid, floored to the fraction width.
    function automatic logic [SIG_W-1:0] sigmoid(input logic signed [DATA_W-1:0] x);
        logic signed [DATA_W:0] xe;
        logic        [DATA_W:0] a;
        logic        [DATA_W+1:0] s;
        logic        [DATA_W+1:0] r;
        xe = {x[DATA_W-1], x};
        a  = (xe < 0) ? (DATA_W+1)'(-xe) : (DATA_W+1)'(xe);
        if (a >= (DATA_W+1)'(SIG_SAT_TH)) begin
            s = (DATA_W+2)'(ONE_Q);
        end else if (a >= (DATA_W+1)'(SIG_MID_TH)) begin
            s = ({1'b0, a} + (DATA_W+2)'(27 * ONE_Q)) >> 5;
        end else if (a >= (DATA_W+1)'(ONE_Q)) begin
            s = ({1'b0, a} + (DATA_W+2)'(5 * ONE_Q)) >> 3;
        end else begin
            s = ({1'b0, a} + (DATA_W+2)'(2 * ONE_Q)) >> 2;
        end
        r = x[DATA_W-1] ? ((DATA_W+2)'(ONE_Q) - s) : s;
        return r[SIG_W-1:0];
    endfunction

endpackage

### rtl/sgb_mul_unit.sv
module sgb_mul_unit (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [sgb_pkg::OPND_W-1:0]   i_a,
    input  logic signed [sgb_pkg::OPND_W-1:0]   i_b,
    output logic signed [sgb_pkg::PROD_W-1:0]   o_rnd
);

    localparam logic signed [sgb_pkg::PROD_W-1:0] RND_HALF =
        sgb_pkg::PROD_W'(1 << (sgb_pkg::FRAC_W - 1));

    logic signed [sgb_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    // Round half up back to the fraction width.
    assign o_rnd = (r_prod + RND_HALF) >>> sgb_pkg::FRAC_W;

endmodule

### rtl/sgb_bias_mem.sv
module sgb_bias_mem #(
    parameter int DEPTH = sgb_pkg::COLUMNS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic signed [sgb_pkg::BIAS_W-1:0]   o_rd_data,
    input  logic                                i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic signed [sgb_pkg::BIAS_W-1:0]   i_wr_data
);

    logic signed [sgb_pkg::BIAS_W-1:0] r_mem [DEPTH];
    logic        [DEPTH-1:0]           r_vld;
    logic signed [sgb_pkg::BIAS_W-1:0] r_rd_data;
    logic                              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // An entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### rtl/silu_gate_backward.sv
// One element at a time: a beat is accepted when the block is idle, then five
// products (SiLU derivative, gate path and logit gradient) run through a single
// shared multiplier, each in a multiply state and then a round state, and a final
// state updates the per-column bias accumulator once the output register is free.
// No new beat is accepted until that bias update is done; the result is
// offered in the cycle after the bias update and may wait in the output register
// while the next beat is accepted. The accumulators read as zero after reset, and
// a column at or above COLUMNS updates nothing and returns a bias total of zero.
module silu_gate_backward #(
    parameter int COLUMNS = sgb_pkg::COLUMNS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sgb_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output sgb_pkg::t_out_beat o_data
);

    localparam int MAX_COLS = 1 << sgb_pkg::COL_W;
    localparam int DEPTH    = (COLUMNS < MAX_COLS) ? COLUMNS : MAX_COLS;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW       = sgb_pkg::DATA_W;
    localparam int OW       = sgb_pkg::OPND_W;
    localparam int PW       = sgb_pkg::PROD_W;
    localparam int BW       = sgb_pkg::BIAS_W;
    localparam int OPT_W    = DW + 2;

    localparam logic signed [PW-1:0] P_DMAX = PW'((1 << (DW - 1)) - 1);
    localparam logic signed [PW-1:0] P_DMIN = -P_DMAX - PW'(1);
    localparam logic signed [DW:0]   S_DMAX = (DW+1)'((1 << (DW - 1)) - 1);
    localparam logic signed [DW:0]   S_DMIN = -S_DMAX - (DW+1)'(1);
    localparam logic signed [BW:0]   B_MAX  = {2'b00, {(BW-1){1'b1}}};
    localparam logic signed [BW:0]   B_MIN  = {2'b11, {(BW-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_RND  = 4'b0100,
        ST_BIAS = 4'b1000
    } t_state;

    typedef enum logic [2:0] {
        STEP_T   = 3'd0,
        STEP_DS  = 3'd1,
        STEP_DG  = 3'd2,
        STEP_GGL = 3'd3,
        STEP_GH  = 3'd4
    } t_step;

    t_state r_state, n_state;
    t_step  r_step,  n_step;

    logic signed [DW-1:0]    r_sum, r_hv, r_gv, r_x;
    logic [sgb_pkg::SIG_W-1:0] r_sig;
    logic [sgb_pkg::COL_W-1:0] r_col;
    logic                    r_col_ok;
    logic                    r_sat;
    logic signed [OPT_W-1:0] r_opt;
    logic signed [OPT_W-1:0] r_ds;
    logic signed [OW-1:0]    r_dg;
    logic signed [DW-1:0]    r_ggl;
    logic signed [DW-1:0]    r_gh;
    logic                    r_out_valid;
    sgb_pkg::t_out_beat      r_out;

    logic                    w_accept;
    logic                    w_load_out;
    logic signed [DW:0]      w_sum_wide;
    logic signed [DW-1:0]    w_sum;
    logic                    w_sum_ovf;
    logic [sgb_pkg::SIG_W-1:0] w_one_m_sig;
    logic signed [OW-1:0]    w_a, w_b;
    logic signed [PW-1:0]    w_rnd;
    logic signed [DW-1:0]    w_clip;
    logic                    w_clip_ovf;
    logic signed [BW-1:0]    w_rd_data;
    logic signed [BW:0]      w_bias_sum;
    logic signed [BW-1:0]    w_total;
    logic                    w_bias_ovf;

    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_load_out = (r_state == ST_BIAS) && (!r_out_valid || i_ready);

    assign w_sum_wide = (DW+1)'(i_data.grad_out) + (DW+1)'(i_data.grad_recurrent);
    assign w_sum_ovf  = (w_sum_wide > S_DMAX) || (w_sum_wide < S_DMIN);
    assign w_sum      = (w_sum_wide > S_DMAX) ? S_DMAX[DW-1:0] :
                        (w_sum_wide < S_DMIN) ? S_DMIN[DW-1:0] : w_sum_wide[DW-1:0];

    assign w_one_m_sig = sgb_pkg::SIG_W'(sgb_pkg::ONE_Q) - r_sig;

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_step)
            STEP_T: begin
                w_a = OW'(r_x);
                w_b = OW'($signed({1'b0, w_one_m_sig}));
            end
            STEP_DS: begin
                w_a = OW'($signed({1'b0, r_sig}));
                w_b = OW'(r_opt);
            end
            STEP_DG: begin
                w_a = OW'(r_sum);
                w_b = OW'(r_hv);
            end
            STEP_GGL: begin
                w_a = r_dg;
                w_b = OW'(r_ds);
            end
            STEP_GH: begin
                w_a = OW'(r_sum);
                w_b = OW'(r_gv);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    sgb_mul_unit u_mul (
        .i_clk (i_clk),
        .i_en  (r_state == ST_MUL),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_rnd (w_rnd)
    );

    assign w_clip_ovf = (w_rnd > P_DMAX) || (w_rnd < P_DMIN);
    assign w_clip     = (w_rnd > P_DMAX) ? P_DMAX[DW-1:0] :
                        (w_rnd < P_DMIN) ? P_DMIN[DW-1:0] : w_rnd[DW-1:0];

    sgb_bias_mem #(
        .DEPTH (DEPTH)
    ) u_bias (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (i_data.column[AW-1:0]),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_load_out && r_col_ok),
        .i_wr_addr (r_col[AW-1:0]),
        .i_wr_data (w_total)
    );

    assign w_bias_sum = (BW+1)'(w_rd_data) + (BW+1)'(r_ggl);
    assign w_bias_ovf = r_col_ok && ((w_bias_sum > B_MAX) || (w_bias_sum < B_MIN));
    assign w_total    = !r_col_ok          ? '0 :
                        (w_bias_sum > B_MAX) ? B_MAX[BW-1:0] :
                        (w_bias_sum < B_MIN) ? B_MIN[BW-1:0] : w_bias_sum[BW-1:0];

    // Sequencer: each step multiplies, then rounds into its own register.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_MUL;
                    n_step  = STEP_T;
                end
            end
            ST_MUL: begin
                n_state = ST_RND;
            end
            ST_RND: begin
                if (r_step == STEP_GH) begin
                    n_state = ST_BIAS;
                end else begin
                    n_state = ST_MUL;
                    n_step  = t_step'(r_step + 3'd1);
                end
            end
            ST_BIAS: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_T;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sum    <= w_sum;
            r_sat    <= w_sum_ovf;
            r_hv     <= i_data.h_new_value;
            r_gv     <= i_data.gate_value;
            r_x      <= i_data.gate_pre;
            r_sig    <= sgb_pkg::sigmoid(i_data.gate_pre);
            r_col    <= i_data.column;
            r_col_ok <= (32'(i_data.column) < COLUMNS);
        end
        if (r_state == ST_RND) begin
            case (r_step)
                STEP_T:   r_opt <= OPT_W'(w_rnd) + OPT_W'(sgb_pkg::ONE_Q);
                STEP_DS:  r_ds  <= OPT_W'(w_rnd);
                STEP_DG:  r_dg  <= OW'(w_rnd);
                STEP_GGL: begin
                    r_ggl <= w_clip;
                    r_sat <= r_sat | w_clip_ovf;
                end
                STEP_GH: begin
                    r_gh  <= w_clip;
                    r_sat <= r_sat | w_clip_ovf;
                end
                default: begin
                    r_opt <= r_opt;
                end
            endcase
        end
        if (w_load_out) begin
            r_out.grad_h_new    <= r_gh;
            r_out.grad_gate_pre <= r_ggl;
            r_out.bias_total    <= w_total;
            r_out.saturated     <= r_sat | w_bias_ovf;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state is not one-hot");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_MUL) && (r_step == STEP_T))
        else $error("accepted beat did not start the first multiply");

    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RND) && (r_step == STEP_GH) |=> (r_state == ST_BIAS))
        else $error("last round did not lead to the bias update");

    a_bias_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BIAS) && r_out_valid && !i_ready |=> (r_state == ST_BIAS))
        else $error("bias update overwrote a result not yet taken");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_step <= STEP_GH))
        else $error("step counter out of range");
`endif

endmodule

### dv/tb_silu_gate_backward.sv
`timescale 1ns / 1ps

module tb_silu_gate_backward;

    localparam int     DW        = sgb_pkg::DATA_W;
    localparam int     FW        = sgb_pkg::FRAC_W;
    localparam int     CW        = sgb_pkg::COL_W;
    localparam int     BW        = sgb_pkg::BIAS_W;
    localparam int     NCOLS     = sgb_pkg::COLUMNS_DEF;
    localparam longint ONE       = longint'(1) << FW;
    localparam longint Q_MAX     = (longint'(1) << (DW - 1)) - 1;
    localparam longint Q_MIN     = -Q_MAX - 1;
    localparam longint MID_LIM   = longint'(1) << (60 - FW);
    localparam longint BIAS_MAX  = 64'sd2147483647;
    localparam longint BIAS_MIN  = -64'sd2147483648;
    localparam int     HOLD_CYCLES   = 300;
    localparam int unsigned RUN_LIMIT = 3000000;

    typedef struct {
        sgb_pkg::t_in_beat  beat;
        bit                 typed;
        sgb_pkg::t_out_beat want;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    sgb_pkg::t_in_beat  i_data;
    logic               o_valid;
    logic               i_ready;
    sgb_pkg::t_out_beat o_data;

    sgb_pkg::t_out_beat grad_results_due[$];
    longint             bias_shadow[NCOLS];
    t_dir_row           dir_rows[$];
    sgb_pkg::t_out_beat oldest_due;
    int                 fail_cnt;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 hold_left;
    bit                 hold_req;
    int unsigned        cycle_cnt;

    silu_gate_backward uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= RUN_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Fixed-point helpers: round half up at the fraction point, and clamp with a flag.
    function automatic longint round_q(input longint v);
        return (v + (ONE >>> 1)) >>> FW;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi,
                                    inout bit clipped);
        if (v > hi) begin
            clipped = 1'b1;
            return hi;
        end
        if (v < lo) begin
            clipped = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Piecewise linear sigmoid, floored, mirrored for negative inputs.
    function automatic longint sigmoid_pwl(input longint x);
        longint a;
        longint s;
        a = (x < 0) ? -x : x;
        if (a >= 5 * ONE) begin
            s = ONE;
        end else if (a >= (19 * ONE) / 8) begin
            s = (a + 27 * ONE) >>> 5;
        end else if (a >= ONE) begin
            s = (a + 5 * ONE) >>> 3;
        end else begin
            s = (a + 2 * ONE) >>> 2;
        end
        return (x < 0) ? ONE - s : s;
    endfunction

    function automatic longint silu_slope(input longint x);
        longint sig;
        longint t;
        sig = sigmoid_pwl(x);
        t   = round_q(x * (ONE - sig));
        return round_q(sig * (ONE + t));
    endfunction

    function automatic sgb_pkg::t_out_beat silu_backward_predict(input sgb_pkg::t_in_beat b);
        sgb_pkg::t_out_beat r;
        bit                 clipped;
        longint             sum;
        longint             gh;
        longint             dg;
        longint             ggl;
        longint             total;
        clipped = 1'b0;
        sum = clip(longint'(b.grad_out) + longint'(b.grad_recurrent), Q_MIN, Q_MAX, clipped);
        gh  = clip(round_q(sum * longint'(b.gate_value)), Q_MIN, Q_MAX, clipped);
        dg  = clip(round_q(sum * longint'(b.h_new_value)), -MID_LIM, MID_LIM, clipped);
        ggl = clip(round_q(dg * silu_slope(longint'(b.gate_pre))), Q_MIN, Q_MAX, clipped);
        total = 0;
        if (b.column < NCOLS) begin
            total = clip(bias_shadow[b.column] + ggl, BIAS_MIN, BIAS_MAX, clipped);
            bias_shadow[b.column] = total;
        end
        r.grad_h_new    = DW'(gh);
        r.grad_gate_pre = DW'(ggl);
        r.bias_total    = BW'(total);
        r.saturated     = clipped;
        return r;
    endfunction

    function automatic t_dir_row dir_row(input int go, input int gr, input int hv,
                                         input int gl, input int gv, input int col,
                                         input bit typed, input int want_gh,
                                         input int want_ggl, input int want_bias,
                                         input bit want_sat);
        t_dir_row r;
        r.beat.grad_out        = DW'(go);
        r.beat.grad_recurrent  = DW'(gr);
        r.beat.h_new_value     = DW'(hv);
        r.beat.gate_pre        = DW'(gl);
        r.beat.gate_value      = DW'(gv);
        r.beat.column          = CW'(col);
        r.typed                = typed;
        r.want.grad_h_new      = DW'(want_gh);
        r.want.grad_gate_pre   = DW'(want_ggl);
        r.want.bias_total      = BW'(want_bias);
        r.want.saturated       = want_sat;
        return r;
    endfunction

    // Mostly moderate magnitudes so that results stay unclipped, with full-range
    // values and the field extremes mixed in.
    function automatic logic signed [DW-1:0] rand_q();
        case ($urandom_range(9)) inside
            [0:2]: return DW'($urandom);
            3: begin
                case ($urandom_range(3))
                    0: return DW'(Q_MAX);
                    1: return DW'(Q_MIN);
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return DW'(int'($urandom_range(16384)) - 8192);
        endcase
    endfunction

    function automatic sgb_pkg::t_in_beat rand_item();
        sgb_pkg::t_in_beat b;
        b.grad_out       = rand_q();
        b.grad_recurrent = rand_q();
        b.h_new_value    = rand_q();
        b.gate_pre       = rand_q();
        b.gate_value     = rand_q();
        // A few hot columns let the bias totals grow.
        b.column = ($urandom_range(3) == 0) ? CW'($urandom_range(3))
                                            : CW'($urandom_range(NCOLS - 1));
        return b;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input sgb_pkg::t_in_beat beat, input bit typed,
                             input sgb_pkg::t_out_beat want);
        sgb_pkg::t_out_beat predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (!o_ready);
        predicted = silu_backward_predict(beat);
        grad_results_due.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (grad_results_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (grad_results_due.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10) begin
                    $display("ERROR: unexpected result gh=%0d ggl=%0d bias=%0d sat=%0b",
                             o_data.grad_h_new, o_data.grad_gate_pre,
                             o_data.bias_total, o_data.saturated);
                end
            end else begin
                oldest_due = grad_results_due.pop_front();
                if (o_data.grad_h_new !== oldest_due.grad_h_new ||
                    o_data.grad_gate_pre !== oldest_due.grad_gate_pre ||
                    o_data.bias_total !== oldest_due.bias_total ||
                    o_data.saturated !== oldest_due.saturated) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("ERROR: want gh=%0d ggl=%0d bias=%0d sat=%0b",
                                 oldest_due.grad_h_new, oldest_due.grad_gate_pre,
                                 oldest_due.bias_total, oldest_due.saturated,
                                 ", got gh=%0d ggl=%0d bias=%0d sat=%0b",
                                 o_data.grad_h_new, o_data.grad_gate_pre,
                                 o_data.bias_total, o_data.saturated);
                    end
                end
            end
        end
    end

    // Receiver side: random stalls, plus a long hold-off on request.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int n_items;
        cycle_cnt      = 0;
        fail_cnt       = 0;
        hold_req       = 1'b0;
        hold_left      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data         = '0;
        foreach (bias_shadow[k]) bias_shadow[k] = 0;

        //                 go      gr      hv      gl      gv  col typed  gh     ggl  bias sat
        dir_rows = {
            dir_row(     0,      0,      0,      0,      0,   0, 1,      0, 0, 0, 0),
            dir_row( 32767,  32767,      0,      0,      0,   1, 1,      0, 0, 0, 1),
            dir_row(-32768, -32768,      0,      0,      0,   2, 1,      0, 0, 0, 1),
            dir_row(  4096,      0,      0,      0,   4096,   3, 1,   4096, 0, 0, 0),
            dir_row( 32767,      0,      0,      0,  32767,   4, 1,  32767, 0, 0, 1),
            dir_row(-32768,      0,      0,      0,  32767,   5, 1, -32768, 0, 0, 1),
            // Sigmoid breakpoints on either side, both signs.
            dir_row(  4096,      0,   4096,      0,   4096,  10, 0, 0, 0, 0, 0),
            dir_row(  4096,      0,   4096,   4095,   4096,  10, 0, 0, 0, 0, 0),
            dir_row(  4096,      0,   4096,   4096,   4096,  11, 0, 0, 0, 0, 0),
            dir_row(  4096,      0,   4096,  -4096,   4096,  11, 0, 0, 0, 0, 0),
            dir_row(  4096,      0,   4096,   9727,   4096,  12, 0, 0, 0, 0, 0),
            dir_row(  4096,      0,   4096,   9728,   4096,  12, 0, 0, 0, 0, 0),
            dir_row(  4096,      0,   4096,  -9728,   4096,  13, 0, 0, 0, 0, 0),
            dir_row(  4096,      0,   4096,  20479,   4096,  13, 0, 0, 0, 0, 0),
            dir_row(  4096,      0,   4096,  20480,   4096,  14, 0, 0, 0, 0, 0),
            dir_row(  4096,      0,   4096, -20480,   4096,  14, 0, 0, 0, 0, 0),
            dir_row(  4096,      0,   4096,  32767,   4096,  15, 0, 0, 0, 0, 0),
            dir_row(  4096,      0,   4096, -32768,   4096,  15, 0, 0, 0, 0, 0),
            // Logit gradient clipping at both ends.
            dir_row( 32767,      0,  32767,      0,      0,  20, 0, 0, 0, 0, 0),
            dir_row(-32768,      0,  32767,      0,      0,  20, 0, 0, 0, 0, 0),
            dir_row(    -1,     -1,     -1,     -1,     -1, 255, 0, 0, 0, 0, 0),
            dir_row( 16384,  16383, -32768,  12000, -32768, 128, 0, 0, 0, 0, 0),
            dir_row(-16384, -16384,  32767, -12000,  32767,  64, 0, 0, 0, 0, 0)
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            send_beat(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].want);
        end
        drain_results();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;  n_items = 200;
                end
                1: begin
                    send_idle_pct = 84; recv_stall_pct = 0;  n_items = 200;
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 84; n_items = 200;
                end
                default: begin
                    send_idle_pct = 27; recv_stall_pct = 27; n_items = 300;
                end
            endcase
            for (int n = 0; n < n_items; n++) begin
                // The sender keeps offering beats while the receiver holds off,
                // so the block backs up and drops its ready.
                if (p == 0 && n == 50) begin
                    @(posedge i_clk);
                    hold_req = 1'b1;
                    @(negedge i_clk);
                end
                send_beat(rand_item(), 1'b0, '0);
            end
            drain_results();
        end

        repeat (40) @(posedge i_clk);
        if (fail_cnt == 0 && grad_results_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
